// ===== sv/gtgs_pkg.sv =====
// Shared constants, codes and types of the grain topple grid sweep block.
package gtgs_pkg;

  // Grid geometry; a cell address is {row, col}
  localparam int GRID_SIZE = 32;
  localparam int COORD_W   = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DEPTH     = 2 ** ADDR_W;
  localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(GRID_SIZE - 1);

  // Field widths
  localparam int CELL_W  = 8;
  localparam int COUNT_W = 14;
  localparam int SWEEP_W = 4;
  localparam int FIELD_W = 5;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;
  localparam int OUT_PAD = OUT_W - CELL_W - COUNT_W;
  localparam int CFG_W   = 5;

  // Arithmetic constants
  localparam logic [CELL_W-1:0]  CELL_MAX     = 8'd255;
  localparam logic [CELL_W-1:0]  TOPPLE_LIMIT = 8'd3;
  localparam logic [CELL_W-1:0]  TOPPLE_LOSS  = 8'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 14'd16383;
  localparam logic [SWEEP_W-1:0] MAX_SWEEPS   = 4'd8;

  // Register reset values
  localparam logic [FIELD_W-1:0] DROP_ROW_RESET = 5'd16;
  localparam logic [FIELD_W-1:0] DROP_COL_RESET = 5'd16;
  localparam logic [SWEEP_W-1:0] SWEEPS_RESET   = 4'd4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DROP_ROW = 2'd0,
    REG_DROP_COL = 2'd1,
    REG_SWEEPS   = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  // Command codes
  typedef enum logic [1:0] {
    CMD_DROP = 2'd0,
    CMD_READ = 2'd1,
    CMD_FILL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Cell unit operations
  typedef enum logic [0:0] {
    ALU_GAIN   = 1'b0,
    ALU_TOPPLE = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              fire;
  } alu_res_t;

endpackage

// ===== sv/gtgs_alu.sv =====
// Shared cell unit: saturating grain gain, or topple test and grain loss.
module gtgs_alu
  import gtgs_pkg::*;
(
  input  alu_op_t           op,
  input  logic [CELL_W-1:0] operand,
  output alu_res_t          res
);

  // Select gain or topple on the cell word
  always_comb begin
    case (op)
      ALU_TOPPLE: begin
        res.fire  = operand > TOPPLE_LIMIT;
        res.value = operand - TOPPLE_LOSS;
      end
      default: begin
        res.fire  = 1'b0;
        res.value = (operand == CELL_MAX) ? CELL_MAX : operand + 8'd1;
      end
    endcase
  end

endmodule

// ===== sv/grain_topple_grid_sweep.sv =====
// Top level of the grain topple grid sweep block: sequencer, grid memory and ports.
// A GRID_SIZE x GRID_SIZE grid of 8-bit grain counts sits in one single-port-write,
// registered-read memory, and every access goes through one shared cell unit under a
// small sequencer, one word at a time. After reset the block clears the grid with
// s_tready low; configuration writes are taken throughout. A read returns the stored
// cell word (zero outside the grid) and a fill rewrites every cell. A drop adds its
// grain and then, on each of up to eight sweeps, tests every cell in raster order; a
// cell that does not topple is passed by, while for a cell that topples the test is
// followed by a read-modify-write of each in-grid neighbour and a re-read of the next
// cell. One item is taken at a time; the result word is held in an output register,
// so the next item may be accepted while it waits.
module grain_topple_grid_sweep
  import gtgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // cmd[1:0], row[6:2], col[11:7], fill_value[19:12]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // cell_value[7:0], topple_count[21:8]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  typedef enum logic [9:0] {
    ST_CLEAR     = 10'b0000000001,
    ST_IDLE      = 10'b0000000010,
    ST_DROP      = 10'b0000000100,
    ST_CELL_RD   = 10'b0000001000,
    ST_CELL_EVAL = 10'b0000010000,
    ST_NBR       = 10'b0000100000,
    ST_READ_WAIT = 10'b0001000000,
    ST_DONE      = 10'b0010000000,
    ST_SPARE0    = 10'b0100000000,
    ST_SPARE1    = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [FIELD_W-1:0] drop_row;
  logic [FIELD_W-1:0] drop_col;
  logic [SWEEP_W-1:0] sweeps_per_drop;

  // Sequencer registers
  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] cur_col;
  logic [SWEEP_W-1:0] sweep_cnt;
  logic [SWEEP_W-1:0] passes;
  logic [1:0]         nbr_dir;
  logic [COUNT_W-1:0] topple_cnt;
  logic [CELL_W-1:0]  res_value;
  logic [CELL_W-1:0]  fill_reg;
  logic               fill_reply;
  logic               read_ok;

  // Memory ports
  logic [CELL_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Cell unit
  alu_op_t  alu_op;
  alu_res_t alu_res;

  // Input fields
  cmd_t               in_cmd;
  logic [FIELD_W-1:0] in_row;
  logic [FIELD_W-1:0] in_col;
  logic [CELL_W-1:0]  in_fill;

  // Derived addresses and walk control
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  drop_addr;
  logic [ADDR_W-1:0]  read_addr;
  logic               drop_in_grid;
  logic               read_in_grid;
  logic               last_col;
  logic               sweep_end;
  logic               all_done;
  logic [COORD_W-1:0] adv_row;
  logic [COORD_W-1:0] adv_col;
  logic [2:0]         first_dir;
  logic [2:0]         next_dir;
  logic [SWEEP_W-1:0] passes_next;

  // Lowest in-grid neighbour direction at or above start; 4 when none is left.
  // Directions: 0 down, 1 up, 2 right, 3 left.
  function automatic logic [2:0] pick_dir(logic [2:0] start, logic [COORD_W-1:0] r,
                                          logic [COORD_W-1:0] c);
    logic [3:0] ok;
    logic [2:0] pick;
    ok   = {c != '0, c != COORD_LAST, r != '0, r != COORD_LAST};
    pick = 3'd4;
    for (int d = 3; d >= 0; d--) begin
      if (3'(d) >= start && ok[d]) begin
        pick = 3'(d);
      end
    end
    return pick;
  endfunction

  function automatic logic [ADDR_W-1:0] nbr_addr(logic [1:0] dir, logic [COORD_W-1:0] r,
                                                 logic [COORD_W-1:0] c);
    logic [ADDR_W-1:0] a;
    case (dir)
      2'd0:    a = {r + COORD_W'(1), c};
      2'd1:    a = {r - COORD_W'(1), c};
      2'd2:    a = {r, c + COORD_W'(1)};
      default: a = {r, c - COORD_W'(1)};
    endcase
    return a;
  endfunction

  assign in_cmd  = cmd_t'(s_tdata[1:0]);
  assign in_row  = s_tdata[6:2];
  assign in_col  = s_tdata[11:7];
  assign in_fill = s_tdata[19:12];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign cur_addr     = {cur_row, cur_col};
  assign drop_addr    = {COORD_W'(drop_row), COORD_W'(drop_col)};
  assign read_addr    = {COORD_W'(in_row), COORD_W'(in_col)};
  assign drop_in_grid = (32'(drop_row) < GRID_SIZE) && (32'(drop_col) < GRID_SIZE);
  assign read_in_grid = (32'(in_row) < GRID_SIZE) && (32'(in_col) < GRID_SIZE);

  // Raster walk: next cell, end of sweep, end of drop
  assign last_col  = (cur_col == COORD_LAST);
  assign sweep_end = last_col && (cur_row == COORD_LAST);
  assign all_done  = sweep_end && (sweep_cnt == passes);
  assign adv_col   = last_col ? '0 : cur_col + COORD_W'(1);
  assign adv_row   = last_col ? (sweep_end ? '0 : cur_row + COORD_W'(1)) : cur_row;

  assign first_dir   = pick_dir(3'd0, cur_row, cur_col);
  assign next_dir    = pick_dir({1'b0, nbr_dir} + 3'd1, cur_row, cur_col);
  assign passes_next = (sweeps_per_drop > MAX_SWEEPS) ? MAX_SWEEPS : sweeps_per_drop;

  gtgs_alu u_alu (
    .op      (alu_op),
    .operand (rd_data),
    .res     (alu_res)
  );

  // Drive memory ports and cell unit from the sequencer state
  always_comb begin
    rd_addr = cur_addr;
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = alu_res.value;
    alu_op  = ALU_GAIN;
    case (state)
      ST_IDLE: begin
        rd_addr = (in_cmd == CMD_READ) ? read_addr : drop_addr;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = fill_reg;
      end
      ST_DROP: begin
        wr_en   = drop_in_grid;
        wr_addr = drop_addr;
      end
      ST_CELL_EVAL: begin
        alu_op = ALU_TOPPLE;
        if (alu_res.fire) begin
          wr_en   = 1'b1;
          rd_addr = nbr_addr(first_dir[1:0], cur_row, cur_col);
        end else begin
          rd_addr = {adv_row, adv_col};
        end
      end
      ST_NBR: begin
        wr_en   = 1'b1;
        wr_addr = nbr_addr(nbr_dir, cur_row, cur_col);
        rd_addr = nbr_addr(next_dir[1:0], cur_row, cur_col);
      end
      default: begin
        rd_addr = cur_addr;
      end
    endcase
  end

  // Grid memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_row        <= DROP_ROW_RESET;
      drop_col        <= DROP_COL_RESET;
      sweeps_per_drop <= SWEEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_DROP_ROW: drop_row        <= cfg_data;
        REG_DROP_COL: drop_col        <= cfg_data;
        REG_SWEEPS:   sweeps_per_drop <= cfg_data[SWEEP_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequence commands, sweeps and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur_row    <= '0;
      cur_col    <= '0;
      fill_reg   <= '0;
      fill_reply <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_value  <= '0;
            topple_cnt <= '0;
            case (in_cmd)
              CMD_DROP: begin
                passes <= passes_next;
                state  <= ST_DROP;
              end
              CMD_READ: begin
                read_ok <= read_in_grid;
                state   <= ST_READ_WAIT;
              end
              CMD_FILL: begin
                fill_reg   <= in_fill;
                fill_reply <= 1'b1;
                cur_row    <= '0;
                cur_col    <= '0;
                state      <= ST_CLEAR;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          cur_row <= adv_row;
          cur_col <= adv_col;
          if (sweep_end) begin
            fill_reply <= 1'b0;
            state      <= fill_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_DROP: begin
          cur_row   <= '0;
          cur_col   <= '0;
          sweep_cnt <= 4'd1;
          state     <= (passes == '0) ? ST_DONE : ST_CELL_RD;
        end
        ST_CELL_RD: begin
          state <= ST_CELL_EVAL;
        end
        ST_CELL_EVAL: begin
          if (alu_res.fire) begin
            if (topple_cnt != COUNT_MAX) begin
              topple_cnt <= topple_cnt + 14'd1;
            end
            nbr_dir <= first_dir[1:0];
            state   <= ST_NBR;
          end else if (all_done) begin
            state <= ST_DONE;
          end else begin
            cur_row <= adv_row;
            cur_col <= adv_col;
            if (sweep_end) begin
              sweep_cnt <= sweep_cnt + 4'd1;
            end
          end
        end
        ST_NBR: begin
          if (!next_dir[2]) begin
            nbr_dir <= next_dir[1:0];
          end else if (all_done) begin
            state <= ST_DONE;
          end else begin
            cur_row <= adv_row;
            cur_col <= adv_col;
            if (sweep_end) begin
              sweep_cnt <= sweep_cnt + 4'd1;
            end
            state <= ST_CELL_RD;
          end
        end
        ST_READ_WAIT: begin
          res_value <= read_ok ? rd_data : '0;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {OUT_PAD'(0), topple_cnt, res_value};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/gtgs_checker.sv =====
// Port checker of the grain topple grid sweep block, bound to its top level.
module gtgs_checker
  import gtgs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Hold input side closed while the grid is cleared after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted straight after reset");

  // Drop ready in the cycle after each accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready straight after an accepted word");

  // Keep a stalled result word
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word dropped or changed while stalled");

  // A result carries a cell value or a topple count, never both; padding stays zero
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:0] == 8'd0 || m_tdata[21:8] == 14'd0)
                  && m_tdata[23:22] == 2'd0))
    else $error("result word mixes read value and topple count");

endmodule

bind grain_topple_grid_sweep gtgs_checker u_gtgs_checker (.*);

// ===== test/tb_grain_topple_grid_sweep.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the grain topple grid sweep block: directed table, then random phases.
module tb_grain_topple_grid_sweep;
  import gtgs_pkg::*;

  localparam int DIRECTED_STEPS  = 31;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 10;
  localparam int MAX_GAP         = 18;
  localparam int TAIL_CYCLES     = 64;

  // One result word as it leaves the block
  typedef struct {
    logic [CELL_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } grid_word_t;

  typedef enum logic {STEP_WORD, STEP_REG} step_kind_t;

  // One row of the directed table; typed rows carry their own expected word
  typedef struct {
    step_kind_t         kind;
    cmd_t               cmd;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [CELL_W-1:0]  fill;
    reg_idx_t           idx;
    logic [CFG_W-1:0]   data;
    bit                 typed;
    logic [CELL_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } plan_step_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;   // cmd, row, col, fill_value
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;        // cell_value, topple_count
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Shadow copy of the grid and of the registers
  logic [CELL_W-1:0]  grid_shadow [GRID_SIZE*GRID_SIZE];
  logic [FIELD_W-1:0] drop_row_shadow = DROP_ROW_RESET;
  logic [FIELD_W-1:0] drop_col_shadow = DROP_COL_RESET;
  logic [SWEEP_W-1:0] sweeps_shadow   = SWEEPS_RESET;

  grid_word_t pending_results [$];
  plan_step_t directed_plan [DIRECTED_STEPS];
  int         mismatches = 0;
  bit         no_gaps = 1'b0;

  grain_topple_grid_sweep u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Add one grain to a cell, holding it at the top of the range
  function automatic void add_grain(input int r, input int c);
    int k;
    k = r * GRID_SIZE + c;
    if (grid_shadow[k] != CELL_MAX) grid_shadow[k] = grid_shadow[k] + 1'b1;
  endfunction

  // Apply one command word to the shadow grid and return the word it should produce
  function automatic grid_word_t predict_word(input cmd_t cmd, input logic [FIELD_W-1:0] row,
                                              input logic [FIELD_W-1:0] col,
                                              input logic [CELL_W-1:0] fill);
    grid_word_t res;
    int passes;
    int topples;
    int k;
    res.value = '0;
    res.count = '0;
    topples = 0;
    case (cmd)
      CMD_DROP: begin
        passes = (sweeps_shadow > MAX_SWEEPS) ? int'(MAX_SWEEPS) : int'(sweeps_shadow);
        if (drop_row_shadow < GRID_SIZE && drop_col_shadow < GRID_SIZE)
          add_grain(drop_row_shadow, drop_col_shadow);
        // In-place raster sweeps: later cells see earlier updates
        for (int s = 0; s < passes; s++)
          for (int r = 0; r < GRID_SIZE; r++)
            for (int c = 0; c < GRID_SIZE; c++) begin
              k = r * GRID_SIZE + c;
              if (grid_shadow[k] > TOPPLE_LIMIT) begin
                grid_shadow[k] = grid_shadow[k] - TOPPLE_LOSS;
                topples++;
                if (r + 1 < GRID_SIZE) add_grain(r + 1, c);
                if (r > 0) add_grain(r - 1, c);
                if (c + 1 < GRID_SIZE) add_grain(r, c + 1);
                if (c > 0) add_grain(r, c - 1);
              end
            end
        res.count = (topples > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(topples);
      end
      CMD_READ: begin
        if (row < GRID_SIZE && col < GRID_SIZE) res.value = grid_shadow[row * GRID_SIZE + col];
      end
      CMD_FILL: begin
        foreach (grid_shadow[i]) grid_shadow[i] = fill;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one command word after a random gap and log its expected result on acceptance
  task automatic send_word(input cmd_t cmd, input logic [FIELD_W-1:0] row,
                           input logic [FIELD_W-1:0] col, input logic [CELL_W-1:0] fill,
                           input bit typed, input logic [CELL_W-1:0] want_value,
                           input logic [COUNT_W-1:0] want_count);
    int gap;
    grid_word_t predicted;
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= IN_W'({fill, col, row, cmd});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = predict_word(cmd, row, col, fill);
    if (typed) begin
      predicted.value = want_value;
      predicted.count = want_count;
    end
    pending_results.push_back(predicted);
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic await_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DROP_ROW: drop_row_shadow = data;
      REG_DROP_COL: drop_col_shadow = data;
      REG_SWEEPS:   sweeps_shadow   = data[SWEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    grid_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[CELL_W-1:0] !== want.value)
          report_mismatch("cell_value", m_tdata[CELL_W-1:0], want.value);
        if (m_tdata[CELL_W +: COUNT_W] !== want.count)
          report_mismatch("topple_count", m_tdata[CELL_W +: COUNT_W], want.count);
      end
    end
  end

  // Result side: stall a random number of cycles before taking each word
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || !(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int pick;
    int sweeps;
    cmd_t cmd;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [CELL_W-1:0] fill;

    foreach (grid_shadow[i]) grid_shadow[i] = '0;

    // kind, cmd, row, col, fill, register, data, typed, cell_value, topple_count
    directed_plan[0]  = '{STEP_WORD, CMD_READ, 0, 0, 0, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[1]  = '{STEP_WORD, CMD_READ, 31, 31, 0, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[2]  = '{STEP_WORD, CMD_DROP, 0, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[3]  = '{STEP_WORD, CMD_READ, 16, 16, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[4]  = '{STEP_WORD, CMD_NONE, 31, 31, 255, REG_UNUSED, 0, 1, 0, 0};
    // no sweeps, drop into the top right corner
    directed_plan[5]  = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_SWEEPS, 0, 0, 0, 0};
    directed_plan[6]  = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_ROW, 0, 0, 0, 0};
    directed_plan[7]  = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_COL, 31, 0, 0, 0};
    directed_plan[8]  = '{STEP_WORD, CMD_FILL, 0, 0, 255, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[9]  = '{STEP_WORD, CMD_DROP, 31, 31, 0, REG_UNUSED, 0, 1, 0, 0};
    // the grain landed on a full cell
    directed_plan[10] = '{STEP_WORD, CMD_READ, 0, 31, 0, REG_UNUSED, 0, 1, 255, 0};
    // full grid, eight sweeps: every cell topples on every sweep
    directed_plan[11] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_SWEEPS, 8, 0, 0, 0};
    directed_plan[12] = '{STEP_WORD, CMD_DROP, 0, 0, 0, REG_UNUSED, 0, 1, 0, 8192};
    directed_plan[13] = '{STEP_WORD, CMD_READ, 31, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    // sweep count above eight, drop into the bottom left corner
    directed_plan[14] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_SWEEPS, 15, 0, 0, 0};
    directed_plan[15] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_ROW, 31, 0, 0, 0};
    directed_plan[16] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_COL, 0, 0, 0, 0};
    directed_plan[17] = '{STEP_WORD, CMD_FILL, 0, 0, 0, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[18] = '{STEP_WORD, CMD_FILL, 0, 0, 4, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[19] = '{STEP_WORD, CMD_DROP, 0, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[20] = '{STEP_WORD, CMD_READ, 0, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[21] = '{STEP_WORD, CMD_READ, 31, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    // top bit of the sweep write is dropped; the unused index changes nothing
    directed_plan[22] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_SWEEPS, 5'b10001, 0, 0, 0};
    directed_plan[23] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_UNUSED, 5'b11111, 0, 0, 0};
    directed_plan[24] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_ROW, 10, 0, 0, 0};
    directed_plan[25] = '{STEP_REG, CMD_NONE, 0, 0, 0, REG_DROP_COL, 21, 0, 0, 0};
    // one grain short everywhere: a single sweep cascades along the raster
    directed_plan[26] = '{STEP_WORD, CMD_FILL, 0, 0, 3, REG_UNUSED, 0, 1, 0, 0};
    directed_plan[27] = '{STEP_WORD, CMD_DROP, 0, 0, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[28] = '{STEP_WORD, CMD_READ, 10, 21, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[29] = '{STEP_WORD, CMD_READ, 11, 21, 0, REG_UNUSED, 0, 0, 0, 0};
    directed_plan[30] = '{STEP_WORD, CMD_DROP, 0, 0, 0, REG_UNUSED, 0, 0, 0, 0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_REG) begin
        await_idle();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        send_word(directed_plan[i].cmd, directed_plan[i].row, directed_plan[i].col,
                  directed_plan[i].fill, directed_plan[i].typed, directed_plan[i].value,
                  directed_plan[i].count);
      end
    end

    // Random phases, each under fresh register settings
    for (int p = 0; p < PHASES; p++) begin
      await_idle();
      no_gaps = ($urandom_range(0, 3) == 0);
      write_reg(REG_DROP_ROW, CFG_W'($urandom));
      write_reg(REG_DROP_COL, CFG_W'($urandom));
      pick = $urandom_range(0, 9);
      if (pick == 0) sweeps = 0;
      else if (pick == 1) sweeps = $urandom_range(8, 15);
      else sweeps = $urandom_range(1, 3);
      write_reg(REG_SWEEPS, CFG_W'(sweeps + 16 * $urandom_range(0, 1)));
      if (pick == 2) write_reg(REG_UNUSED, CFG_W'($urandom));

      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        pick = $urandom_range(0, 99);
        row  = FIELD_W'($urandom);
        col  = FIELD_W'($urandom);
        fill = CELL_W'($urandom);
        if (pick < 35) begin
          cmd = CMD_DROP;
        end else if (pick < 75) begin
          cmd = CMD_READ;
          // aim half the reads around the drop cell
          if (pick < 55) begin
            row = drop_row_shadow + FIELD_W'($urandom_range(0, 2)) - 1'b1;
            col = drop_col_shadow + FIELD_W'($urandom_range(0, 2)) - 1'b1;
          end
        end else if (pick < 90) begin
          cmd = CMD_FILL;
          if ($urandom_range(0, 9) < 7) fill = CELL_W'($urandom_range(0, 7));
        end else begin
          cmd = CMD_NONE;
        end
        send_word(cmd, row, col, fill, 1'b0, '0, '0);
        // hold off now and then until the grid has settled
        if ($urandom_range(0, 11) == 0) await_idle();
      end
    end

    await_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[grain_topple_grid_sweep] OK");
    end else begin
      $display("[grain_topple_grid_sweep] ERROR");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #50000000;
    $display("[grain_topple_grid_sweep] ERROR");
    $finish;
  end

endmodule
